@@ rtl/tct_pkg.sv @@
// ----------------------------------------------------------------------------
// tct_pkg
// Types, codes and sizes shared by the tag count table modules.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int DEPTH    = 64;
  localparam int TAG_BITS = 16;

  localparam int TAG_W    = 16;
  localparam int CNT_W    = 32;
  localparam int KEY_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2
  } tct_op_e;

  typedef enum logic [2:0] {
    ST_CHANGED  = 3'd0,
    ST_INVALID  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } tct_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WRITE
  } tct_state_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [TAG_W-1:0]        tag;
    logic signed [CNT_W-1:0] amount;
  } tct_in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    changed;
    logic signed [CNT_W-1:0] old_count;
    logic signed [CNT_W-1:0] new_count;
  } tct_out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic signed [CNT_W-1:0] count;
  } tct_entry_t;

  typedef struct packed {
    logic                    hit;
    logic                    free_found;
    logic signed [CNT_W-1:0] cur;
  } tct_scan_t;

  typedef struct packed {
    logic                    wr_en;
    logic                    use_free;
    logic                    set_used;
    logic                    clr_used;
    logic signed [CNT_W-1:0] wr_count;
  } tct_act_t;

endpackage

@@ rtl/tct_ram.sv @@
// ----------------------------------------------------------------------------
// tct_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tct_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tct_update.sv @@
// ----------------------------------------------------------------------------
// tct_update
// Decides the result word and the write-back for one operation from the
// outcome of the table scan.
// ----------------------------------------------------------------------------
module tct_update (
  input  tct_pkg::tct_in_t   req,
  input  tct_pkg::tct_scan_t scan,
  output tct_pkg::tct_out_t  res,
  output tct_pkg::tct_act_t  act
);
  import tct_pkg::*;

  logic [KEY_BITS-1:0]     key;
  logic signed [CNT_W-1:0] cur_v;
  logic signed [CNT_W:0]   sum;
  logic signed [CNT_W-1:0] add_v;
  logic                    amt_pos;

  assign key     = req.tag[KEY_BITS-1:0];
  assign cur_v   = scan.hit ? scan.cur : '0;
  assign sum     = {scan.cur[CNT_W-1], scan.cur} + {req.amount[CNT_W-1], req.amount};
  assign add_v   = (sum[CNT_W] != sum[CNT_W-1]) ? CNT_MAX : sum[CNT_W-1:0];
  assign amt_pos = !req.amount[CNT_W-1] && (req.amount != '0);

  always_comb begin
    res          = '0;
    act          = '0;
    res.status   = ST_IGNORED;
    res.old_count = cur_v;
    res.new_count = cur_v;
    if (key == '0) begin
      res.status    = ST_INVALID;
      res.old_count = '0;
      res.new_count = '0;
    end else begin
      unique case (req.operation)
        OP_REMOVE: begin
          if (!amt_pos) begin
            res.status = ST_IGNORED;
          end else if (!scan.hit) begin
            res.status    = ST_NOTFOUND;
            res.old_count = '0;
            res.new_count = '0;
          end else if (scan.cur <= req.amount) begin
            res.status    = ST_CHANGED;
            res.changed   = 1'b1;
            res.new_count = '0;
            act.clr_used  = 1'b1;
          end else begin
            res.status    = ST_CHANGED;
            res.changed   = 1'b1;
            res.new_count = scan.cur - req.amount;
            act.wr_en     = 1'b1;
            act.wr_count  = scan.cur - req.amount;
          end
        end
        OP_ADD, OP_SET: begin
          if (req.operation == OP_ADD && !amt_pos) begin
            res.status = ST_IGNORED;
          end else if (scan.hit) begin
            res.status    = ST_CHANGED;
            res.changed   = 1'b1;
            res.new_count = (req.operation == OP_ADD) ? add_v : req.amount;
            act.wr_en     = 1'b1;
            act.wr_count  = (req.operation == OP_ADD) ? add_v : req.amount;
          end else if (!scan.free_found) begin
            res.status    = ST_FULL;
            res.old_count = '0;
            res.new_count = '0;
          end else begin
            res.status    = ST_CHANGED;
            res.changed   = 1'b1;
            res.old_count = '0;
            res.new_count = req.amount;
            act.wr_en     = 1'b1;
            act.use_free  = 1'b1;
            act.set_used  = 1'b1;
            act.wr_count  = req.amount;
          end
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
    end
  end

endmodule

@@ rtl/tag_count_table_core.sv @@
// ----------------------------------------------------------------------------
// tag_count_table_core
// Bounded table of unique nonzero tags with signed counts: add, set, remove.
// ----------------------------------------------------------------------------
// Each accepted word (start high while busy is low) scans every one of the
// DEPTH table slots through the single read port of the entry RAM, one slot a
// cycle, then writes back at most once. busy stays high through the S_SCAN,
// S_DRAIN and S_WRITE states after the accepting edge; the result word is on
// result for exactly one cycle with done high, registered from the S_WRITE
// state, and a new word may be accepted in that same cycle. The receiver
// cannot stall: done is a strobe and result must be taken when it shows.
module tag_count_table_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tct_pkg::tct_in_t   item,
  output logic               done,
  output tct_pkg::tct_out_t  result
);
  import tct_pkg::*;

  localparam int EW = $bits(tct_entry_t);

  tct_state_e state, state_next;

  tct_in_t                 req;
  logic [DEPTH-1:0]        used;
  logic [AW-1:0]           scan_idx;
  logic [AW-1:0]           cmp_idx;
  logic                    cmp_v;
  logic                    hit;
  logic [AW-1:0]           hit_idx;
  logic signed [CNT_W-1:0] cur;
  logic                    free_found;
  logic [AW-1:0]           free_idx;

  logic                    rd_en;
  logic                    wr_go;
  logic                    scan_last;
  logic                    accept;
  tct_entry_t              rd_entry;
  tct_entry_t              wr_entry;
  logic [EW-1:0]           rd_word;
  logic [AW-1:0]           wr_addr;
  tct_scan_t               scan;
  tct_out_t                res;
  tct_act_t                act;

  assign accept    = start && !busy;
  assign scan_last = (scan_idx == AW'(DEPTH - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_SCAN;
      S_SCAN:  if (scan_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != S_IDLE);
    rd_en = (state == S_SCAN);
    wr_go = (state == S_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  tct_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_go && act.wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (scan_idx),
    .rdata (rd_word)
  );

  assign rd_entry       = rd_word;
  assign wr_addr        = act.use_free ? free_idx : hit_idx;
  assign wr_entry.key   = req.tag[KEY_BITS-1:0];
  assign wr_entry.count = act.wr_count;

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_v    <= 1'b0;
    end else begin
      cmp_v <= rd_en;
      if (accept) begin
        scan_idx <= '0;
      end else if (rd_en) begin
        scan_idx <= scan_last ? '0 : scan_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_v) begin
      if (used[cmp_idx]) begin
        if (!hit && rd_entry.key == req.tag[KEY_BITS-1:0]) begin
          hit <= 1'b1;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_v && used[cmp_idx] && !hit && rd_entry.key == req.tag[KEY_BITS-1:0]) begin
      hit_idx <= cmp_idx;
      cur     <= rd_entry.count;
    end
    if (cmp_v && !used[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  assign scan.hit        = hit;
  assign scan.free_found = free_found;
  assign scan.cur        = cur;

  tct_update u_update (
    .req  (req),
    .scan (scan),
    .res  (res),
    .act  (act)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_go) begin
      if (act.set_used) begin
        used[free_idx] <= 1'b1;
      end
      if (act.clr_used) begin
        used[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= wr_go;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      result <= res;
    end
  end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tag_count_table_core.
// ----------------------------------------------------------------------------
// Words are queued by a stimulus process and fed to the block by a clocked
// driver that inserts random idle bursts. A clocked monitor runs a local copy
// of the tag table on every accepted word and checks each result strobe, field
// by field, against the oldest predicted word. Directed words cover invalid
// tags, ignored amounts, the unknown operation code, saturation and delete
// edges. The random phases use a small hot set of tags, then fill the table,
// hit it while it is full, and finally drain it by removes.
// ----------------------------------------------------------------------------
module tb_top;
  import tct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = DEPTH + 8;
  localparam int MAX_REPORTS = 10;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  tct_in_t  item;
  logic     done;
  tct_out_t result;

  tag_count_table_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #4 clk = ~clk;

  // local copy of the table
  logic [KEY_BITS-1:0]     tbl_key   [DEPTH];
  logic signed [CNT_W-1:0] tbl_count [DEPTH];
  logic                    tbl_used  [DEPTH];

  tct_in_t  pending_words[$];
  tct_out_t expected_results[$];

  logic took;
  logic quiet;
  int   gap_left;
  int   queued_words;
  int   taken_words;
  int   mismatches;
  int   idle_cycles;

  logic [TAG_W-1:0] hot_tags[16];

  function automatic tct_out_t apply_word(tct_in_t w);
    tct_out_t              r;
    logic [KEY_BITS-1:0]   k;
    int                    hit;
    int                    slot;
    logic signed [CNT_W:0] cur;
    logic signed [CNT_W:0] amt;
    logic signed [CNT_W:0] nv;
    r = '0;
    k = w.tag[KEY_BITS-1:0];
    amt = $signed(w.amount);
    if (k == '0) begin
      r.status = ST_INVALID;
      return r;
    end
    hit = -1;
    slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_used[i]) begin
        if (hit < 0 && tbl_key[i] == k) hit = i;
      end else if (slot < 0) begin
        slot = i;
      end
    end
    cur = '0;
    if (hit >= 0) cur = tbl_count[hit];
    if (w.operation == OP_UNKNOWN || (w.operation != OP_SET && amt <= 0)) begin
      r.status = ST_IGNORED;
      r.old_count = cur[CNT_W-1:0];
      r.new_count = cur[CNT_W-1:0];
      return r;
    end
    if (w.operation == OP_REMOVE) begin
      if (hit < 0) begin
        r.status = ST_NOTFOUND;
        return r;
      end
      r.status = ST_CHANGED;
      r.changed = 1'b1;
      r.old_count = cur[CNT_W-1:0];
      if (cur <= amt) begin
        tbl_used[hit] = 1'b0;
        r.new_count = '0;
      end else begin
        nv = cur - amt;
        tbl_count[hit] = nv[CNT_W-1:0];
        r.new_count = nv[CNT_W-1:0];
      end
      return r;
    end
    if (hit >= 0) begin
      nv = (w.operation == OP_ADD) ? cur + amt : amt;
      if (nv > CNT_MAX) nv = CNT_MAX;
      tbl_count[hit] = nv[CNT_W-1:0];
      r.status = ST_CHANGED;
      r.changed = 1'b1;
      r.old_count = cur[CNT_W-1:0];
      r.new_count = nv[CNT_W-1:0];
      return r;
    end
    if (slot < 0) begin
      r.status = ST_FULL;
      return r;
    end
    tbl_used[slot] = 1'b1;
    tbl_key[slot] = k;
    tbl_count[slot] = amt[CNT_W-1:0];
    r.status = ST_CHANGED;
    r.changed = 1'b1;
    r.new_count = amt[CNT_W-1:0];
    return r;
  endfunction

  function automatic tct_in_t mk_word(logic [1:0] op, logic [TAG_W-1:0] tag,
                                      logic [CNT_W-1:0] amt);
    tct_in_t w;
    w.operation = op;
    w.tag = tag;
    w.amount = amt;
    return w;
  endfunction

  function automatic logic [CNT_W-1:0] rand_amount();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: begin
        return CNT_W'($urandom_range(1, 1000));
      end
      4, 5: begin
        return CNT_W'($urandom);
      end
      6: begin
        return -CNT_W'($urandom_range(0, 1000));
      end
      7: begin
        case ($urandom_range(0, 3))
          0: return CNT_MAX;
          1: return {1'b1, {(CNT_W-1){1'b0}}};
          2: return '0;
          default: return CNT_W'(1);
        endcase
      end
      default: begin
        return CNT_W'($urandom) >> 1;
      end
    endcase
  endfunction

  function automatic logic [1:0] rand_op();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return OP_ADD;
    if (r < 13) return OP_SET;
    if (r < 19) return OP_REMOVE;
    return OP_UNKNOWN;
  endfunction

  function automatic logic [TAG_W-1:0] wide_tag(int idx);
    return TAG_W'(idx * 613 + 1);
  endfunction

  function automatic logic [TAG_W-1:0] hot_tag();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return TAG_W'($urandom);
    return hot_tags[$urandom_range(0, 15)];
  endfunction

  task automatic push_word(tct_in_t w);
    @(posedge clk);
    pending_words.push_back(w);
    queued_words++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (taken_words != queued_words || expected_results.size() != 0);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      item <= '0;
      gap_left <= 0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 15);
        start <= 1'b0;
      end else if (pending_words.size() != 0) begin
        item <= pending_words.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!quiet && $urandom_range(0, 31) == 0) begin
      // pull the waiting word back and idle for a while
      pending_words.push_front(item);
      gap_left <= $urandom_range(0, 15);
      start <= 1'b0;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    tct_out_t exp_w;
    if (rst) begin
      took <= 1'b0;
      idle_cycles <= 0;
      taken_words <= 0;
      mismatches <= 0;
      for (int i = 0; i < DEPTH; i++) begin
        tbl_used[i] = 1'b0;
        tbl_key[i] = '0;
        tbl_count[i] = '0;
      end
    end else begin
      took <= start && !busy;
      if (start && !busy) begin
        expected_results.push_back(apply_word(item));
        taken_words <= taken_words + 1;
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("unexpected result word: st=%0d ch=%0d old=%0d new=%0d",
                     result.status, result.changed, result.old_count, result.new_count);
        end else begin
          exp_w = expected_results.pop_front();
          if (result.status !== exp_w.status || result.changed !== exp_w.changed ||
              result.old_count !== exp_w.old_count ||
              result.new_count !== exp_w.new_count) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORTS)
              $display({"mismatch: exp st=%0d ch=%0d old=%0d new=%0d, ",
                        "got st=%0d ch=%0d old=%0d new=%0d"},
                       exp_w.status, exp_w.changed, exp_w.old_count, exp_w.new_count,
                       result.status, result.changed, result.old_count, result.new_count);
          end
        end
      end
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    logic [1:0] op;
    clk = 1'b0;
    rst = 1'b1;
    quiet = 1'b0;
    queued_words = 0;
    for (int i = 0; i < 16; i++) hot_tags[i] = TAG_W'($urandom_range(1, 65535));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words
    push_word(mk_word(OP_ADD, 16'h0000, 32'd5));
    push_word(mk_word(OP_SET, 16'hFFFF, 32'h7FFF_FFFF));
    push_word(mk_word(OP_ADD, 16'hFFFF, 32'd1));
    push_word(mk_word(OP_ADD, 16'hFFFF, 32'h7FFF_FFFF));
    push_word(mk_word(OP_REMOVE, 16'h0001, 32'd1));
    push_word(mk_word(OP_ADD, 16'h0001, 32'd0));
    push_word(mk_word(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF));
    push_word(mk_word(OP_REMOVE, 16'hFFFF, 32'h8000_0000));
    push_word(mk_word(OP_UNKNOWN, 16'hFFFF, 32'd7));
    push_word(mk_word(OP_UNKNOWN, 16'h0000, 32'd7));
    push_word(mk_word(OP_SET, 16'h8000, 32'h8000_0000));
    push_word(mk_word(OP_ADD, 16'h8000, 32'h7FFF_FFFF));
    push_word(mk_word(OP_REMOVE, 16'h8000, 32'd1));
    push_word(mk_word(OP_SET, 16'h0001, 32'd0));
    push_word(mk_word(OP_REMOVE, 16'h0001, 32'd1));
    push_word(mk_word(OP_ADD, 16'h5555, 32'h5555_5555));
    push_word(mk_word(OP_ADD, 16'hAAAA, 32'h2AAA_AAAA));
    push_word(mk_word(OP_REMOVE, 16'h5555, 32'd5));
    push_word(mk_word(OP_REMOVE, 16'hFFFF, 32'h7FFF_FFFF));
    push_word(mk_word(OP_SET, 16'hAAAA, 32'hFFFF_FFFB));
    push_word(mk_word(OP_ADD, 16'hAAAA, 32'd10));
    push_word(mk_word(OP_REMOVE, 16'h5555, 32'h7FFF_FFFF));
    push_word(mk_word(OP_UNKNOWN, 16'hAAAA, 32'h8000_0000));

    // hold off until the block has answered everything
    wait_drained();

    // hot set of tags, all operations
    for (int i = 0; i < 150; i++) push_word(mk_word(rand_op(), hot_tag(), rand_amount()));

    // fill the table with distinct tags
    for (int i = 0; i < 80; i++) begin
      op = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_SET;
      push_word(mk_word(op, wide_tag(i), CNT_W'($urandom_range(1, 100000))));
    end

    // full table: hits on stored tags and refused inserts
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(0, 3) == 0)
        push_word(mk_word(rand_op(), hot_tag(), rand_amount()));
      else
        push_word(mk_word(rand_op(), wide_tag($urandom_range(0, 119)), rand_amount()));
    end

    // drain by removes, no idling
    quiet = 1'b1;
    for (int i = 0; i < 100; i++) begin
      op = ($urandom_range(0, 9) < 7) ? OP_REMOVE : rand_op();
      push_word(mk_word(op, wide_tag($urandom_range(0, 89)), rand_amount()));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
